// ===== rtl/core/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants for the Q24.8 fixed-point arithmetic unit.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int WORD_W            = 32;
    localparam int KIND_W            = 4;
    localparam int DEFAULT_FRAC_BITS = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD      = 4'd0,
        KIND_SUB      = 4'd1,
        KIND_MUL      = 4'd2,
        KIND_DIV      = 4'd3,
        KIND_GT       = 4'd4,
        KIND_LT       = 4'd5,
        KIND_GE       = 4'd6,
        KIND_LE       = 4'd7,
        KIND_EQ       = 4'd8,
        KIND_NE       = 4'd9,
        KIND_MIN      = 4'd10,
        KIND_MAX      = 4'd11,
        KIND_INC      = 4'd12,
        KIND_DEC      = 4'd13,
        KIND_TO_INT   = 4'd14,
        KIND_FROM_INT = 4'd15
    } kind_t;

    // Sideband that rides along the divider stages
    typedef struct packed {
        logic valid;
        logic negate;
    } div_ctl_t;

endpackage

// ===== rtl/core/fpa_div_pipe.sv =====
// ----------------------------------------------------------------------------
// fpa_div_pipe
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module fpa_div_pipe #(
    parameter int FRAC_BITS = fpa_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fpa_pkg::div_ctl_t               ctl_in,
    input  logic [fpa_pkg::WORD_W+FRAC_BITS-1:0] numer,
    input  logic [fpa_pkg::WORD_W-1:0]      denom,
    output fpa_pkg::div_ctl_t               ctl_out,
    output logic [fpa_pkg::WORD_W+FRAC_BITS-1:0] quot
);

    localparam int DW = fpa_pkg::WORD_W + FRAC_BITS;
    localparam int RW = fpa_pkg::WORD_W;

    fpa_pkg::div_ctl_t ctl_reg   [DW];
    logic [DW-1:0]     num_reg   [DW];
    logic [DW-1:0]     q_reg     [DW];
    logic [RW-1:0]     rem_reg   [DW];
    logic [RW-1:0]     den_reg   [DW];

    genvar i;
    generate
        for (i = 0; i < DW; i++) begin : g_stage
            fpa_pkg::div_ctl_t ctl_prev;
            logic [DW-1:0]     num_prev;
            logic [DW-1:0]     q_prev;
            logic [RW-1:0]     rem_prev;
            logic [RW-1:0]     den_prev;
            logic [RW:0]       trial;
            logic [RW:0]       diff;
            logic              fits;

            if (i == 0) begin : g_first
                assign ctl_prev = ctl_in;
                assign num_prev = numer;
                assign q_prev   = '0;
                assign rem_prev = '0;
                assign den_prev = denom;
            end else begin : g_rest
                assign ctl_prev = ctl_reg[i-1];
                assign num_prev = num_reg[i-1];
                assign q_prev   = q_reg[i-1];
                assign rem_prev = rem_reg[i-1];
                assign den_prev = den_reg[i-1];
            end

            // Shift in the next dividend bit and try a subtract
            always_comb
            begin
                trial = {rem_prev, num_prev[DW-1]};
                diff  = trial - {1'b0, den_prev};
                fits  = (trial >= {1'b0, den_prev});
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    ctl_reg[i] <= '0;
                end
                else
                begin
                    ctl_reg[i] <= ctl_prev;
                end
            end

            // Advance payload of this stage
            always_ff @(posedge clk)
            begin
                num_reg[i] <= {num_prev[DW-2:0], 1'b0};
                q_reg[i]   <= {q_prev[DW-2:0], fits};
                rem_reg[i] <= fits ? diff[RW-1:0] : trial[RW-1:0];
                den_reg[i] <= den_prev;
            end
        end
    endgenerate

    assign ctl_out = ctl_reg[DW-1];
    assign quot    = q_reg[DW-1];

endmodule

// ===== rtl/core/fixed_point_alu_q24_8_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8_unit
// Signed Q24.8 fixed-point ALU: add, sub, mul, div, compares, min/max,
// inc/dec and integer conversions, fully pipelined.
//
//   channel  | handshake      | fields
//   ---------+----------------+------------------------------------------
//   command  | start / busy   | kind, operand_a, operand_b
//   result   | done (strobe)  | value, compare_true, divide_error
//
// One command is taken every cycle; busy stays low.
// Commands pass through stage 0, stage 1, the divider or its delay line, and an output
// register; the divider, resolving one quotient bit per stage, sets the depth.
// Every operation travels through the same depth, so results leave in order.
// Reset clears the valid bits and the divider sideband; the receiver cannot stall.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8_unit #(
    parameter int FRAC_BITS = fpa_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [fpa_pkg::KIND_W-1:0]        kind,
    input  logic signed [fpa_pkg::WORD_W-1:0] operand_a,
    input  logic signed [fpa_pkg::WORD_W-1:0] operand_b,
    output logic                              done,
    output logic signed [fpa_pkg::WORD_W-1:0] value,
    output logic                              compare_true,
    output logic                              divide_error
);

    localparam int W   = fpa_pkg::WORD_W;
    localparam int DW  = W + FRAC_BITS;
    localparam int LAT = DW + 3;

    typedef struct packed {
        logic         is_div;
        logic         derr;
        logic         cmp;
        logic [W-1:0] val;
    } line_t;

    // Stage 0: capture command
    logic                 s0_valid_reg;
    fpa_pkg::kind_t       s0_kind_reg;
    logic signed [W-1:0]  s0_a_reg;
    logic signed [W-1:0]  s0_b_reg;

    // Stage 1: simple ops and raw product
    logic                   s1_valid_reg;
    logic                   s1_is_mul_reg;
    logic                   s1_is_div_reg;
    logic                   s1_derr_reg;
    logic                   s1_cmp_reg;
    logic [W-1:0]           s1_val_reg;
    logic signed [2*W-1:0]  s1_prod_reg;
    logic                   s1_neg_reg;
    logic [DW-1:0]          s1_num_reg;
    logic [W-1:0]           s1_den_reg;

    logic [W-1:0]           s1_val_next;
    logic                   s1_cmp_next;
    logic signed [DW-1:0]   num_signed;
    logic signed [2*W-1:0]  prod_shift;

    logic                   line_valid_reg [DW];
    line_t                  line_reg [DW];
    fpa_pkg::div_ctl_t      div_ctl_in;
    fpa_pkg::div_ctl_t      div_ctl_out;
    logic [DW-1:0]          div_quot;
    logic [DW-1:0]          quot_signed;

    logic                   done_reg;
    logic [W-1:0]           value_reg;
    logic                   cmp_reg;
    logic                   derr_reg;

    assign busy = 1'b0;

    // Capture command on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_kind_reg <= fpa_pkg::kind_t'(kind);
        s0_a_reg    <= operand_a;
        s0_b_reg    <= operand_b;
    end

    // Decode the simple operations
    always_comb
    begin
        s1_val_next = '0;
        s1_cmp_next = 1'b0;
        unique case (s0_kind_reg)
            fpa_pkg::KIND_ADD:      s1_val_next = s0_a_reg + s0_b_reg;
            fpa_pkg::KIND_SUB:      s1_val_next = s0_a_reg - s0_b_reg;
            fpa_pkg::KIND_MUL:      s1_val_next = '0;
            fpa_pkg::KIND_DIV:      s1_val_next = '0;
            fpa_pkg::KIND_GT:       s1_cmp_next = (s0_a_reg >  s0_b_reg);
            fpa_pkg::KIND_LT:       s1_cmp_next = (s0_a_reg <  s0_b_reg);
            fpa_pkg::KIND_GE:       s1_cmp_next = (s0_a_reg >= s0_b_reg);
            fpa_pkg::KIND_LE:       s1_cmp_next = (s0_a_reg <= s0_b_reg);
            fpa_pkg::KIND_EQ:       s1_cmp_next = (s0_a_reg == s0_b_reg);
            fpa_pkg::KIND_NE:       s1_cmp_next = (s0_a_reg != s0_b_reg);
            fpa_pkg::KIND_MIN:
                s1_val_next = (s0_a_reg < s0_b_reg) ? s0_a_reg : s0_b_reg;
            fpa_pkg::KIND_MAX:
                s1_val_next = (s0_a_reg > s0_b_reg) ? s0_a_reg : s0_b_reg;
            fpa_pkg::KIND_INC:      s1_val_next = s0_a_reg + W'(1);
            fpa_pkg::KIND_DEC:      s1_val_next = s0_a_reg - W'(1);
            fpa_pkg::KIND_TO_INT:   s1_val_next = s0_a_reg >>> FRAC_BITS;
            fpa_pkg::KIND_FROM_INT: s1_val_next = s0_a_reg << FRAC_BITS;
            default:                s1_val_next = '0;
        endcase
    end

    // Widen dividend and take magnitudes for the divider
    assign num_signed = DW'(s0_a_reg) <<< FRAC_BITS;

    always_ff @(posedge clk)
    begin
        s1_is_mul_reg <= (s0_kind_reg == fpa_pkg::KIND_MUL);
        s1_is_div_reg <= (s0_kind_reg == fpa_pkg::KIND_DIV);
        s1_derr_reg   <= (s0_kind_reg == fpa_pkg::KIND_DIV) && (s0_b_reg == '0);
        s1_cmp_reg    <= s1_cmp_next;
        s1_val_reg    <= s1_val_next;
        s1_prod_reg   <= (2*W)'(s0_a_reg) * (2*W)'(s0_b_reg);
        s1_neg_reg    <= s0_a_reg[W-1] ^ s0_b_reg[W-1];
        s1_num_reg    <= s0_a_reg[W-1] ? DW'(-num_signed) : DW'(num_signed);
        s1_den_reg    <= s0_b_reg[W-1] ? W'(-s0_b_reg) : W'(s0_b_reg);
    end

    assign div_ctl_in.valid  = s1_valid_reg;
    assign div_ctl_in.negate = s1_neg_reg;

    fpa_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (div_ctl_in),
        .numer   (s1_num_reg),
        .denom   (s1_den_reg),
        .ctl_out (div_ctl_out),
        .quot    (div_quot)
    );

    assign prod_shift = s1_prod_reg >>> FRAC_BITS;

    // Delay the other results to line up with the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DW; k++)
            begin
                line_valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            line_valid_reg[0] <= s1_valid_reg;
            for (int k = 1; k < DW; k++)
            begin
                line_valid_reg[k] <= line_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg[0].is_div <= s1_is_div_reg;
        line_reg[0].derr   <= s1_derr_reg;
        line_reg[0].cmp    <= s1_cmp_reg;
        line_reg[0].val    <= s1_is_mul_reg ? prod_shift[W-1:0] : s1_val_reg;
        for (int k = 1; k < DW; k++)
        begin
            line_reg[k] <= line_reg[k-1];
        end
    end

    // Restore quotient sign, truncating toward zero
    assign quot_signed = div_ctl_out.negate ? DW'(-div_quot) : div_quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= line_valid_reg[DW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_reg  <= line_reg[DW-1].cmp;
        derr_reg <= line_reg[DW-1].derr;
        if (line_reg[DW-1].derr)
        begin
            value_reg <= '0;
        end
        else if (line_reg[DW-1].is_div)
        begin
            value_reg <= quot_signed[W-1:0];
        end
        else
        begin
            value_reg <= line_reg[DW-1].val;
        end
    end

    assign done         = done_reg;
    assign value        = value_reg;
    assign compare_true = cmp_reg;
    assign divide_error = derr_reg;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result strobe missing at fixed latency");
    a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
        line_valid_reg[DW-1] |-> div_ctl_out.valid)
        else $error("divider out of step with result line");
    a_derr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && divide_error) |-> (value == '0 && !compare_true))
        else $error("divide error with nonzero result");
`endif

endmodule
